### design/volume_hat_density_filter_macros.svh
// Assertion macros shared by the design files.
`ifndef VOLUME_HAT_DENSITY_FILTER_MACROS_SVH
`define VOLUME_HAT_DENSITY_FILTER_MACROS_SVH
`define VHDF_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define VHDF_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

### design/vhdf_pkg.sv
`default_nettype none
package vhdf_pkg;
   localparam int MAX_DIM_DEF = 32;
   localparam int MAX_RADIUS_DEF = 3;
   localparam int ONE_Q12 = 4096;
   localparam int QUEUE_DEPTH = 2;
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ = 1'b1;
   localparam logic [1:0] REG_SIZE_X = 2'd0;
   localparam logic [1:0] REG_SIZE_Y = 2'd1;
   localparam logic [1:0] REG_SIZE_Z = 2'd2;
   localparam logic [1:0] REG_RADIUS = 2'd3;

   typedef struct packed {
      logic       cmd;
      logic [4:0] x;
      logic [4:0] y;
      logic [4:0] z;
      logic [15:0] dens;
      logic        in_range;
   } item_type;

   // Rounded square root in Q3.12 of a small integer (at most 63).
   function automatic logic [14:0] dist_q12(input logic [5:0] d2);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] b;
      n = 64'(d2) << 24;
      r = '0;
      b = 64'd1 << 40;
      for (int i = 0; i < 21; i++) begin
         if (b > n) b = b >> 2;
      end
      for (int i = 0; i < 21; i++) begin
         if (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      if (n > r) r = r + 1;
      return r[14:0];
   endfunction

   // Offset lengths for every squared offset that a six-bit index can hold.
   function automatic logic [63:0][14:0] dist_table();
      logic [63:0][14:0] t;
      for (int i = 0; i < 64; i++) begin
         t[i] = dist_q12(6'(i));
      end
      return t;
   endfunction
endpackage
`default_nettype wire

### design/vhdf_front.sv
`default_nettype none
module vhdf_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   input  wire logic       cmd,
   input  wire logic [4:0] cx,
   input  wire logic [4:0] cy,
   input  wire logic [4:0] cz,
   input  wire logic [15:0] dens,
   input  wire logic [5:0] nx,
   input  wire logic [5:0] ny,
   input  wire logic [5:0] nz,
   output vhdf_pkg::item_type q_item,
   output logic      q_valid,
   input  wire logic q_pop
);
   localparam int QD = vhdf_pkg::QUEUE_DEPTH;
   localparam int AW = $clog2(QD);
   vhdf_pkg::item_type mem_ff [QD];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic push;
   vhdf_pkg::item_type it;

   assign busy = (cnt_ff == (AW+1)'(QD));
   assign push = start && !busy;
   assign q_valid = (cnt_ff != '0);
   assign q_item = mem_ff[rp_ff];

   always_comb begin
      it.cmd = cmd;
      it.x = cx;
      it.y = cy;
      it.z = cz;
      it.dens = dens;
      it.in_range = (6'(cx) < nx) && (6'(cy) < ny) && (6'(cz) < nz);
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = q_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= it;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   `include "volume_hat_density_filter_macros.svh"
   `VHDF_ASSERT_IMPL(a_no_pop_empty, clock, reset, q_pop, q_valid)
   `VHDF_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= (AW+1)'(QD))
   `VHDF_ASSERT_IMPL(a_push_room, clock, reset, push, cnt_ff < (AW+1)'(QD))
endmodule
`default_nettype wire

### design/vhdf_back.sv
`default_nettype none
module vhdf_back #(
   parameter int MAX_DIM = vhdf_pkg::MAX_DIM_DEF,
   parameter int MAX_RADIUS = vhdf_pkg::MAX_RADIUS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire vhdf_pkg::item_type q_item,
   input  wire logic q_valid,
   output logic      q_pop,
   input  wire logic [5:0] nx,
   input  wire logic [5:0] ny,
   input  wire logic [5:0] nz,
   input  wire logic [13:0] radius,
   output logic      rsp_valid,
   output logic [15:0] rsp_filtered
);
   localparam int DW = $clog2(MAX_DIM);
   localparam int AW = 3 * DW;
   localparam int DEPTH = 1 << AW;
   localparam logic [14:0] RMAX = 15'(MAX_RADIUS * vhdf_pkg::ONE_Q12);
   localparam int NW = 48;
   localparam int WW = 24;
   localparam logic [63:0][14:0] DIST_TAB = vhdf_pkg::dist_table();

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_WALK = 5'b00010,
      S_DRAIN = 5'b00100,
      S_DIV = 5'b01000,
      S_OUT = 5'b10000
   } state_type;

   logic [15:0] mem [DEPTH];
   logic [15:0] rdata_ff;
   state_type st_ff, st_in;
   vhdf_pkg::item_type cur_ff;
   logic [14:0] rad_ff;
   logic [2:0] span_ff;
   logic signed [3:0] dx_ff, dy_ff, dz_ff;
   logic [1:0] vpipe_ff;
   logic [14:0] w1_ff;
   logic [NW-1:0] num_ff;
   logic [WW-1:0] wsum_ff;
   logic [NW-1:0] rem_ff;
   logic [NW-1:0] quo_ff;
   logic [5:0] bit_ff;
   logic [15:0] res_ff;
   logic res_v_ff;

   logic signed [7:0] px, py, pz;
   logic in_vol;
   logic [5:0] d2;
   logic [14:0] dq;
   logic last;
   logic [14:0] rad_c;
   logic [AW-1:0] raddr;
   logic [NW:0] trial;
   logic [30:0] prod;

   always_comb begin
      rad_c = (15'(radius) > RMAX) ? RMAX : 15'(radius);
      px = 8'(signed'({3'b0, cur_ff.x})) + 8'(dx_ff);
      py = 8'(signed'({3'b0, cur_ff.y})) + 8'(dy_ff);
      pz = 8'(signed'({3'b0, cur_ff.z})) + 8'(dz_ff);
      in_vol = (px >= 0) && (px < signed'({2'b0, nx})) && (py >= 0)
         && (py < signed'({2'b0, ny})) && (pz >= 0) && (pz < signed'({2'b0, nz}));
      d2 = 6'(8'(dx_ff) * 8'(dx_ff)) + 6'(8'(dy_ff) * 8'(dy_ff))
         + 6'(8'(dz_ff) * 8'(dz_ff));
      dq = DIST_TAB[d2];
      raddr = {pz[DW-1:0], py[DW-1:0], px[DW-1:0]};
      last = (dx_ff == 4'(span_ff)) && (dy_ff == 4'(span_ff)) && (dz_ff == 4'(span_ff));
      trial = {rem_ff, quo_ff[NW-1]} - (NW+1)'(wsum_ff);
      prod = w1_ff * rdata_ff;
      q_pop = (st_ff == S_IDLE) && q_valid;
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (q_valid && q_item.cmd == vhdf_pkg::CMD_READ) begin
            st_in = q_item.in_range ? S_WALK : S_OUT;
         end
         S_WALK: if (last) st_in = S_DRAIN;
         S_DRAIN: if (vpipe_ff == 2'b00) st_in = S_DIV;
         S_DIV: if (bit_ff == '0) st_in = S_OUT;
         S_OUT: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE && q_valid) begin
         cur_ff <= q_item;
         rad_ff <= rad_c;
         span_ff <= 3'((rad_c + 15'(vhdf_pkg::ONE_Q12 - 1)) >> 12);
         dx_ff <= -4'(3'((rad_c + 15'(vhdf_pkg::ONE_Q12 - 1)) >> 12));
         dy_ff <= -4'(3'((rad_c + 15'(vhdf_pkg::ONE_Q12 - 1)) >> 12));
         dz_ff <= -4'(3'((rad_c + 15'(vhdf_pkg::ONE_Q12 - 1)) >> 12));
         num_ff <= '0;
         wsum_ff <= '0;
         res_ff <= '0;
         if (q_item.cmd == vhdf_pkg::CMD_WRITE && q_item.in_range)
            mem[{DW'(q_item.z), DW'(q_item.y), DW'(q_item.x)}] <= q_item.dens;
      end
      rdata_ff <= mem[raddr];
      if (st_ff == S_WALK) begin
         if (dx_ff == 4'(span_ff)) begin
            dx_ff <= -4'(span_ff);
            if (dy_ff == 4'(span_ff)) begin
               dy_ff <= -4'(span_ff);
               dz_ff <= dz_ff + 4'sd1;
            end else begin
               dy_ff <= dy_ff + 4'sd1;
            end
         end else begin
            dx_ff <= dx_ff + 4'sd1;
         end
         w1_ff <= (in_vol && dq < rad_ff) ? rad_ff - dq : '0;
      end
      if (vpipe_ff[0] && w1_ff != '0) begin
         num_ff <= num_ff + NW'(prod);
         wsum_ff <= wsum_ff + WW'(w1_ff);
      end
      if (st_ff == S_DRAIN && vpipe_ff == 2'b00) begin
         quo_ff <= num_ff + NW'(wsum_ff >> 1);
         rem_ff <= '0;
         bit_ff <= 6'(NW - 1);
      end
      if (st_ff == S_DIV) begin
         if (!trial[NW]) begin
            rem_ff <= trial[NW-1:0];
            quo_ff <= {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[NW-2:0], quo_ff[NW-1]};
            quo_ff <= {quo_ff[NW-2:0], 1'b0};
         end
         bit_ff <= bit_ff - 6'd1;
         if (bit_ff == '0) res_ff <= (wsum_ff == '0) ? 16'd0
            : (!trial[NW] ? {quo_ff[14:0], 1'b1} : {quo_ff[14:0], 1'b0});
      end
      if (reset) begin
         st_ff <= S_IDLE;
         vpipe_ff <= '0;
         res_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         vpipe_ff <= {vpipe_ff[0], st_ff == S_WALK};
         res_v_ff <= (st_ff == S_OUT);
      end
   end

   assign rsp_valid = res_v_ff;
   assign rsp_filtered = res_ff;

   `include "volume_hat_density_filter_macros.svh"
   `VHDF_ASSERT_IMPL(a_pop_idle, clock, reset, q_pop, st_ff == S_IDLE)
   `VHDF_ASSERT_NEXT(a_out_strobe, clock, reset, st_ff == S_OUT, rsp_valid)
   `VHDF_ASSERT_IMPL(a_onehot, clock, reset, 1'b1, $onehot(st_ff))
endmodule
`default_nettype wire

### design/volume_hat_density_filter.sv
`default_nettype none
// Commands are taken while busy is low and pass through a two-entry queue, so new commands
// can enter while a read runs. A write leaves the queue once the back end is idle and
// updates the cell as it leaves. A read walks the (2R+1)^3 window around the cell
// (R = ceil(radius), at most MAX_RADIUS), one memory read and multiply-accumulate per cycle,
// drains the read and weight registers and then runs a 48-bit restoring divide. The back end
// takes the next queued command only after the current read has passed its output state. A
// read outside the volume skips the walk and strobes 0. The result appears on rsp_valid for
// exactly one cycle and the receiver cannot stall it.
module volume_hat_density_filter #(
   parameter int MAX_DIM = vhdf_pkg::MAX_DIM_DEF,
   parameter int MAX_RADIUS = vhdf_pkg::MAX_RADIUS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   input  wire logic       req_command,
   input  wire logic [4:0] req_cell_x,
   input  wire logic [4:0] req_cell_y,
   input  wire logic [4:0] req_cell_z,
   input  wire logic [15:0] req_density,
   output logic      rsp_valid,
   output logic [15:0] rsp_filtered,
   input  wire logic psel,
   input  wire logic penable,
   input  wire logic pwrite,
   input  wire logic [3:0] paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic      pready
);
   logic [5:0] sx_ff, sy_ff, sz_ff, nx, ny, nz;
   logic [13:0] rad_ff;
   vhdf_pkg::item_type q_item;
   logic q_valid, q_pop;

   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff <= 6'd32;
         sy_ff <= 6'd32;
         sz_ff <= 6'd32;
         rad_ff <= 14'd6144;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            vhdf_pkg::REG_SIZE_X: sx_ff <= pwdata[5:0];
            vhdf_pkg::REG_SIZE_Y: sy_ff <= pwdata[5:0];
            vhdf_pkg::REG_SIZE_Z: sz_ff <= pwdata[5:0];
            vhdf_pkg::REG_RADIUS: rad_ff <= pwdata[13:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (paddr[3:2])
         vhdf_pkg::REG_SIZE_X: prdata = 32'(sx_ff);
         vhdf_pkg::REG_SIZE_Y: prdata = 32'(sy_ff);
         vhdf_pkg::REG_SIZE_Z: prdata = 32'(sz_ff);
         vhdf_pkg::REG_RADIUS: prdata = 32'(rad_ff);
         default: prdata = '0;
      endcase
      nx = (int'(sx_ff) > MAX_DIM) ? 6'(MAX_DIM) : sx_ff;
      ny = (int'(sy_ff) > MAX_DIM) ? 6'(MAX_DIM) : sy_ff;
      nz = (int'(sz_ff) > MAX_DIM) ? 6'(MAX_DIM) : sz_ff;
   end

   vhdf_front u_front (
      .clock, .reset, .start, .busy,
      .cmd(req_command), .cx(req_cell_x), .cy(req_cell_y), .cz(req_cell_z),
      .dens(req_density), .nx, .ny, .nz, .q_item, .q_valid, .q_pop
   );

   vhdf_back #(.MAX_DIM(MAX_DIM), .MAX_RADIUS(MAX_RADIUS)) u_back (
      .clock, .reset, .q_item, .q_valid, .q_pop, .nx, .ny, .nz,
      .radius(rad_ff), .rsp_valid, .rsp_filtered
   );
endmodule
`default_nettype wire

### sim/tb_volume_hat_density_filter.sv
`timescale 1ns / 100ps

class density_scoreboard;
   logic [15:0] cells [32768];
   logic [5:0]  size_x;
   logic [5:0]  size_y;
   logic [5:0]  size_z;
   logic [13:0] radius;
   logic [15:0] pending [$];
   int          errors;

   function new();
      foreach (cells[i]) cells[i] = '0;
      size_x = 6'd32;
      size_y = 6'd32;
      size_z = 6'd32;
      radius = 14'd6144;
      errors = 0;
   endfunction

   function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
         vhdf_pkg::REG_SIZE_X: size_x = value[5:0];
         vhdf_pkg::REG_SIZE_Y: size_y = value[5:0];
         vhdf_pkg::REG_SIZE_Z: size_z = value[5:0];
         vhdf_pkg::REG_RADIUS: radius = value[13:0];
         default: ;
      endcase
   endfunction

   function int limit(logic [5:0] s);
      return (s > 32) ? 32 : int'(s);
   endfunction

   function int hat_radius();
      return (radius > 14'd12288) ? 12288 : int'(radius);
   endfunction

   function int hat_span();
      return (hat_radius() + 4095) >> 12;
   endfunction

   // Offset length in Q3.12, rounded to nearest.
   function longint unsigned offset_length(int d2);
      longint unsigned n;
      longint unsigned r;
      longint unsigned t;
      n = longint'(d2) << 24;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= n) r = t;
      end
      if (n - r * r > r) r = r + 1;
      return r;
   endfunction

   function void note_input(logic cmd, int x, int y, int z, logic [15:0] dens);
      bit in_vol;
      longint unsigned num;
      longint unsigned wsum;
      longint unsigned d;
      longint unsigned q;
      int rad;
      int sp;
      int px;
      int py;
      int pz;
      in_vol = x < limit(size_x) && y < limit(size_y) && z < limit(size_z);
      if (cmd == vhdf_pkg::CMD_WRITE) begin
         if (in_vol) cells[(z * 32 + y) * 32 + x] = dens;
         return;
      end
      if (!in_vol) begin
         pending = {pending, 16'd0};
         return;
      end
      rad = hat_radius();
      sp = hat_span();
      num = 0;
      wsum = 0;
      for (int dz = -sp; dz <= sp; dz++) begin
         for (int dy = -sp; dy <= sp; dy++) begin
            for (int dx = -sp; dx <= sp; dx++) begin
               px = x + dx;
               py = y + dy;
               pz = z + dz;
               if (px < 0 || px >= limit(size_x) || py < 0 || py >= limit(size_y)
                   || pz < 0 || pz >= limit(size_z)) continue;
               d = offset_length(dx * dx + dy * dy + dz * dz);
               if (d >= rad) continue;
               num += (rad - d) * cells[(pz * 32 + py) * 32 + px];
               wsum += rad - d;
            end
         end
      end
      q = (wsum != 0) ? (num + wsum / 2) / wsum : 0;
      pending = {pending, q[15:0]};
   endfunction

   function void check_result(logic [15:0] got);
      logic [15:0] want;
      if (pending.size() == 0) begin
         errors++;
         $display("%0t: unexpected transaction, filtered = %0d", $time, got);
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         errors++;
         $display("%0t: filtered expected %0d, actual %0d", $time, want, got);
      end
   endfunction
endclass

module tb_volume_hat_density_filter;
   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_command;
   logic [4:0]  req_cell_x;
   logic [4:0]  req_cell_y;
   logic [4:0]  req_cell_z;
   logic [15:0] req_density;
   logic        rsp_valid;
   logic [15:0] rsp_filtered;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   density_scoreboard filter_board;
   bit written [32768];
   int idle_pct;

   volume_hat_density_filter uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_cell_x(req_cell_x), .req_cell_y(req_cell_y),
      .req_cell_z(req_cell_z), .req_density(req_density),
      .rsp_valid(rsp_valid), .rsp_filtered(rsp_filtered),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) filter_board.check_result(rsp_filtered);
   end

   task automatic send(logic cmd, int x, int y, int z, logic [15:0] dens);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_command = cmd;
      req_cell_x = x[4:0];
      req_cell_y = y[4:0];
      req_cell_z = z[4:0];
      req_density = dens;
      while (busy) @(negedge clock);
      filter_board.note_input(cmd, x, y, z, dens);
      if (cmd == vhdf_pkg::CMD_WRITE && x < filter_board.limit(filter_board.size_x)
          && y < filter_board.limit(filter_board.size_y)
          && z < filter_board.limit(filter_board.size_z))
         written[(z * 32 + y) * 32 + x] = 1'b1;
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (filter_board.pending.size() != 0) @(negedge clock);
   endtask

   task automatic set_reg(logic [1:0] idx, int value);
      drain();
      repeat (500) @(negedge clock);
      while (busy) @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      filter_board.set_reg(idx, value);
   endtask

   task automatic configure(int sx, int sy, int sz, int rad);
      set_reg(vhdf_pkg::REG_SIZE_X, sx);
      set_reg(vhdf_pkg::REG_SIZE_Y, sy);
      set_reg(vhdf_pkg::REG_SIZE_Z, sz);
      set_reg(vhdf_pkg::REG_RADIUS, rad);
   endtask

   // Every in-volume cell that a read can reach must hold a written density.
   task automatic read_cell(int x, int y, int z);
      int sp;
      int px;
      int py;
      int pz;
      sp = filter_board.hat_span();
      if (x < filter_board.limit(filter_board.size_x) && y < filter_board.limit(filter_board.size_y)
          && z < filter_board.limit(filter_board.size_z)) begin
         for (int dz = -sp; dz <= sp; dz++) begin
            for (int dy = -sp; dy <= sp; dy++) begin
               for (int dx = -sp; dx <= sp; dx++) begin
                  px = x + dx;
                  py = y + dy;
                  pz = z + dz;
                  if (px < 0 || px >= filter_board.limit(filter_board.size_x) || py < 0
                      || py >= filter_board.limit(filter_board.size_y) || pz < 0
                      || pz >= filter_board.limit(filter_board.size_z)) continue;
                  if (!written[(pz * 32 + py) * 32 + px])
                     send(vhdf_pkg::CMD_WRITE, px, py, pz, 16'($urandom_range(32768)));
               end
            end
         end
      end
      send(vhdf_pkg::CMD_READ, x, y, z, 16'($urandom));
   endtask

   task automatic random_phase(int count, int idle);
      int x;
      int y;
      int z;
      logic [15:0] dens;
      idle_pct = idle;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            x = $urandom_range(31);
            y = $urandom_range(31);
            z = $urandom_range(31);
         end else begin
            x = $urandom_range(filter_board.limit(filter_board.size_x) - 1);
            y = $urandom_range(filter_board.limit(filter_board.size_y) - 1);
            z = $urandom_range(filter_board.limit(filter_board.size_z) - 1);
         end
         dens = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
         if ($urandom_range(1) == 0) send(vhdf_pkg::CMD_WRITE, x, y, z, dens);
         else read_cell(x, y, z);
         if (i == count / 2 && idle == 15) drain();
      end
   endtask

   initial begin
      filter_board = new();
      idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_command = vhdf_pkg::CMD_WRITE;
      req_cell_x = '0;
      req_cell_y = '0;
      req_cell_z = '0;
      req_density = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(vhdf_pkg::CMD_WRITE, 0, 0, 0, 16'd0);
      send(vhdf_pkg::CMD_WRITE, 31, 31, 31, 16'hFFFF);
      send(vhdf_pkg::CMD_WRITE, 30, 31, 31, 16'd32768);
      read_cell(31, 31, 31);
      read_cell(0, 0, 0);
      configure(4, 4, 4, 0);
      read_cell(1, 2, 3);
      read_cell(4, 0, 0);
      send(vhdf_pkg::CMD_WRITE, 0, 5, 0, 16'd1234);
      configure(63, 63, 63, 16383);
      read_cell(31, 0, 31);
      configure(0, 0, 0, 1);
      send(vhdf_pkg::CMD_WRITE, 0, 0, 0, 16'd77);
      read_cell(0, 0, 0);
      configure(1, 1, 1, 1);
      send(vhdf_pkg::CMD_WRITE, 0, 0, 0, 16'd32768);
      read_cell(0, 0, 0);

      configure(5, 4, 6, 6144);
      random_phase(50, 0);
      configure(2, 2, 63, 12288);
      random_phase(50, 71);
      configure(6, 3, 5, 4097);
      random_phase(50, 71);
      configure(4, 6, 6, 16383);
      random_phase(50, 15);
      configure(1, 1, 1, 1);
      random_phase(25, 0);
      configure(0, 6, 6, 8192);
      random_phase(20, 15);
      configure(6, 6, 6, 2000);
      random_phase(55, 15);

      drain();
      repeat (500) @(posedge clock);
      if (filter_board.errors == 0 && filter_board.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
